/* src/usmc_pkg.sv */
// Package: item types, command codes, register indexes and reset values.
`timescale 1ns / 1ps
package usmc_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       on_led;
    logic       reverse_led;
    logic [3:0] phase_drive;
    logic       stepped;
  } out_item_t;

  localparam logic       REQ_CMD  = 1'b0;
  localparam logic       REQ_TICK = 1'b1;

  localparam logic [7:0] CMD_START  = 8'h31;
  localparam logic [7:0] CMD_STOP   = 8'h32;
  localparam logic [7:0] CMD_TOGGLE = 8'h30;
  localparam logic [7:0] CMD_FASTER = 8'h2B;
  localparam logic [7:0] CMD_SLOWER = 8'h2D;

  localparam logic       CFG_BASE_PERIOD  = 1'b0;
  localparam logic       CFG_PERIOD_SLOPE = 1'b1;

  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] BASE_PERIOD_RST  = 16'd200;
  localparam logic [7:0]  PERIOD_SLOPE_RST = 8'd15;
  localparam logic [7:0]  SPEED_RST        = 8'd10;
  localparam logic [7:0]  SPEED_MAX        = 8'd255;

endpackage

/* src/usmc_core.sv */
// Motor control state, configuration registers and per-item result logic.
`timescale 1ns / 1ps
module usmc_core
  import usmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  accept,
  input  in_item_t              item,
  output out_item_t             result
);

  logic [15:0] base_period_r;
  logic [7:0]  period_slope_r;
  logic [7:0]  speed_r,       speed_nxt;
  logic        reverse_r,     reverse_nxt;
  logic        running_r,     running_nxt;
  logic [1:0]  phase_index_r, phase_index_nxt;
  logic [3:0]  coil_pins_r,   coil_pins_nxt;
  logic [15:0] wait_count_r,  wait_count_nxt;
  logic [15:0] drop;
  logic [15:0] period;
  logic        txv;
  logic        step;

  assign drop   = {8'd0, speed_r} * {8'd0, period_slope_r};
  assign period = (drop >= base_period_r) ? 16'd0 : (base_period_r - drop);

  always_comb begin
    speed_nxt       = speed_r;
    reverse_nxt     = reverse_r;
    running_nxt     = running_r;
    phase_index_nxt = phase_index_r;
    coil_pins_nxt   = coil_pins_r;
    wait_count_nxt  = wait_count_r;
    txv             = 1'b0;
    step            = 1'b0;
    if (item.req_type == REQ_CMD) begin
      case (item.rx_byte)
        CMD_START: begin
          running_nxt = 1'b1;
          txv         = 1'b1;
        end
        CMD_STOP: begin
          running_nxt = 1'b0;
        end
        CMD_TOGGLE: begin
          reverse_nxt = ~reverse_r;
        end
        CMD_FASTER: begin
          if (speed_r != SPEED_MAX) speed_nxt = speed_r + 8'd1;
          txv = 1'b1;
        end
        CMD_SLOWER: begin
          if (speed_r != 8'd0) speed_nxt = speed_r - 8'd1;
          txv = 1'b1;
        end
        default: begin
          txv = 1'b1;
        end
      endcase
    end else if (wait_count_r != 16'd0) begin
      wait_count_nxt = wait_count_r - 16'd1;
    end else if (running_r && (speed_r != 8'd0)) begin
      coil_pins_nxt   = 4'b0001 << phase_index_r;
      phase_index_nxt = reverse_r ? (phase_index_r - 2'd1) : (phase_index_r + 2'd1);
      wait_count_nxt  = period;
      step            = 1'b1;
    end
  end

  always_comb begin
    result.tx_valid    = txv;
    result.tx_byte     = txv ? speed_nxt : 8'd0;
    result.on_led      = running_nxt;
    result.reverse_led = reverse_nxt;
    result.phase_drive = coil_pins_nxt;
    result.stepped     = step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_period_r  <= BASE_PERIOD_RST;
      period_slope_r <= PERIOD_SLOPE_RST;
      speed_r        <= SPEED_RST;
      reverse_r      <= 1'b0;
      running_r      <= 1'b0;
      phase_index_r  <= 2'd0;
      coil_pins_r    <= 4'd0;
      wait_count_r   <= 16'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BASE_PERIOD) base_period_r <= cfg_wdata;
        if (cfg_index == CFG_PERIOD_SLOPE) period_slope_r <= cfg_wdata[7:0];
      end
      if (accept) begin
        speed_r       <= speed_nxt;
        reverse_r     <= reverse_nxt;
        running_r     <= running_nxt;
        phase_index_r <= phase_index_nxt;
        coil_pins_r   <= coil_pins_nxt;
        wait_count_r  <= wait_count_nxt;
      end
    end
  end

endmodule

/* src/usmc_out_buf.sv */
// Result register with a skid stage on the output channel.
`timescale 1ns / 1ps
module usmc_out_buf
  import usmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  out_item_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      main_v_r;
  logic      skid_v_r;
  out_item_t main_r;
  out_item_t skid_r;
  logic      take;
  logic      main_free;

  assign in_ready  = ~skid_v_r;
  assign take      = in_valid & in_ready;
  assign main_free = out_ready | ~main_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (main_free) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= take;
      end
    end else if (take) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_v_r) main_r <= skid_r;
      else if (take) main_r <= in_data;
    end else if (take) begin
      skid_r <= in_data;
    end
  end

endmodule

/* src/uart_stepper_motor_controller.sv */
// Top level: stepper motor wave-drive controller fed by command bytes and ticks.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_ready    in_item_t  (req_type, rx_byte)
//   out_      output     out_valid / out_ready  out_item_t (tx, leds, coils, stepped)
//   cfg_      input      cfg_we                 cfg_index, cfg_wdata
//
// One item per cycle while in_ready is high; each result is registered before out_.
// The 8x8 speed-times-slope product and the period clamp are combinational.
// in_ready drops only when both the result register and the skid stage are full.
// Synchronous active-low reset restores the register and motor reset values.
`timescale 1ns / 1ps
module uart_stepper_motor_controller
  import usmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      accept;
  out_item_t result;

  assign accept = in_valid & in_ready;

  usmc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .item     (in_data),
    .result   (result)
  );

  usmc_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (result),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("skid stage full while result register empty");

  a_quiet_tx_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tx_valid |-> out_data.tx_byte == 8'd0)
    else $error("tx_byte nonzero without tx_valid");

  a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stepped |-> $onehot(out_data.phase_drive) && !out_data.tx_valid)
    else $error("step item without a single driven coil");
`endif

endmodule

/* dv/testbench.sv */
// Stepper motor controller testbench: directed rows and random traffic checked by a predictor.
`timescale 1ns / 1ps
module testbench;
  import usmc_pkg::*;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t status;
  } dir_row_t;

  localparam out_item_t NO_STATUS = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_BASE_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [15:0] m_base = BASE_PERIOD_RST;
  logic [7:0]  m_slope = PERIOD_SLOPE_RST;
  logic [7:0]  m_speed = SPEED_RST;
  logic        m_reverse = 1'b0;
  logic        m_running = 1'b0;
  logic [1:0]  m_phase = 2'd0;
  logic [3:0]  m_coils = 4'd0;
  logic [15:0] m_wait = 16'd0;

  out_item_t status_fifo[$];
  int        mismatches = 0;
  bit        last_stepped = 1'b0;
  bit        pacing = 1'b1;
  int        burst_left = 0;
  int        ready_mode = 0;
  int        ready_left = 0;
  logic [7:0] ready_count = '0;

  dir_row_t dir_rows [18] = '{
    '{'{REQ_TICK, 8'h00}, 1'b1, '{1'b0, 8'd0, 1'b0, 1'b0, 4'd0, 1'b0}},
    '{'{REQ_CMD, 8'hFF}, 1'b1, '{1'b1, 8'd10, 1'b0, 1'b0, 4'd0, 1'b0}},
    '{'{REQ_CMD, CMD_STOP}, 1'b1, '{1'b0, 8'd0, 1'b0, 1'b0, 4'd0, 1'b0}},
    '{'{REQ_CMD, CMD_FASTER}, 1'b1, '{1'b1, 8'd11, 1'b0, 1'b0, 4'd0, 1'b0}},
    '{'{REQ_CMD, CMD_SLOWER}, 1'b1, '{1'b1, 8'd10, 1'b0, 1'b0, 4'd0, 1'b0}},
    '{'{REQ_CMD, CMD_START}, 1'b1, '{1'b1, 8'd10, 1'b1, 1'b0, 4'd0, 1'b0}},
    '{'{REQ_TICK, 8'hFF}, 1'b1, '{1'b0, 8'd0, 1'b1, 1'b0, 4'b0001, 1'b1}},
    '{'{REQ_TICK, 8'h31}, 1'b0, NO_STATUS},
    '{'{REQ_CMD, CMD_TOGGLE}, 1'b1, '{1'b0, 8'd0, 1'b1, 1'b1, 4'b0001, 1'b0}},
    '{'{REQ_CMD, 8'h00}, 1'b0, NO_STATUS},
    '{'{REQ_CMD, 8'h80}, 1'b0, NO_STATUS},
    '{'{REQ_CMD, 8'h2A}, 1'b0, NO_STATUS},
    '{'{REQ_CMD, 8'h2C}, 1'b0, NO_STATUS},
    '{'{REQ_CMD, CMD_TOGGLE}, 1'b0, NO_STATUS},
    '{'{REQ_CMD, CMD_STOP}, 1'b0, NO_STATUS},
    '{'{REQ_TICK, 8'h55}, 1'b0, NO_STATUS},
    '{'{REQ_CMD, 8'h7F}, 1'b0, NO_STATUS},
    '{'{REQ_CMD, CMD_SLOWER}, 1'b0, NO_STATUS}
  };

  uart_stepper_motor_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_item_t next_status(in_item_t it);
    out_item_t  r;
    logic [16:0] drop;
    r = '0;
    if (it.req_type == REQ_CMD) begin
      case (it.rx_byte)
        CMD_START: begin
          m_running = 1'b1;
          r.tx_valid = 1'b1;
        end
        CMD_STOP: m_running = 1'b0;
        CMD_TOGGLE: m_reverse = ~m_reverse;
        CMD_FASTER: begin
          if (m_speed != SPEED_MAX) m_speed = m_speed + 8'd1;
          r.tx_valid = 1'b1;
        end
        CMD_SLOWER: begin
          if (m_speed != 8'd0) m_speed = m_speed - 8'd1;
          r.tx_valid = 1'b1;
        end
        default: r.tx_valid = 1'b1;
      endcase
    end else if (m_wait != 16'd0) begin
      m_wait = m_wait - 16'd1;
    end else if (m_running && m_speed != 8'd0) begin
      m_coils = 4'b0001 << m_phase;
      m_phase = m_reverse ? m_phase - 2'd1 : m_phase + 2'd1;
      drop = {9'd0, m_speed} * {9'd0, m_slope};
      m_wait = (drop >= {1'b0, m_base}) ? 16'd0 : m_base - drop[15:0];
      r.stepped = 1'b1;
    end
    r.tx_byte = r.tx_valid ? m_speed : 8'd0;
    r.on_led = m_running;
    r.reverse_led = m_reverse;
    r.phase_drive = m_coils;
    return r;
  endfunction

  function automatic in_item_t cmd_item(logic [7:0] b);
    in_item_t it;
    it.req_type = REQ_CMD;
    it.rx_byte = b;
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it.req_type = REQ_TICK;
    it.rx_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic send(input in_item_t it, input bit typed = 1'b0,
                      input out_item_t typed_status = NO_STATUS);
    out_item_t predicted;
    int        gap;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predicted = next_status(it);
    last_stepped = predicted.stepped;
    status_fifo.push_back(typed ? typed_status : predicted);
    if (!pacing) return;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (status_fifo.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] base, input logic [15:0] slope_word);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE_PERIOD;
    cfg_wdata <= base;
    @(posedge clk);
    m_base = base;
    cfg_index <= CFG_PERIOD_SLOPE;
    cfg_wdata <= slope_word;
    @(posedge clk);
    m_slope = slope_word[7:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic tick_until_step();
    do send(tick_item()); while (!last_stepped);
  endtask

  task automatic random_traffic(input int count);
    int         sent;
    int         len;
    logic [7:0] b;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          len = $urandom_range(1, 24);
          repeat (len) send(tick_item());
          sent += len;
        end
        4, 5: begin
          case ($urandom_range(0, 7))
            0, 1, 2: b = CMD_START;
            3: b = CMD_STOP;
            4: b = CMD_TOGGLE;
            5: b = CMD_FASTER;
            6: b = CMD_SLOWER;
            default: b = 8'($urandom_range(0, 255));
          endcase
          send(cmd_item(b));
          sent++;
        end
        6: begin
          len = $urandom_range(1, 16);
          b = $urandom_range(0, 1) ? CMD_FASTER : CMD_SLOWER;
          repeat (len) send(cmd_item(b));
          sent += len;
        end
        7: begin
          send(in_item_t'(9'($urandom_range(0, 511))));
          sent++;
        end
        8: begin
          send(cmd_item(8'h28 + 8'($urandom_range(0, 10))));
          sent++;
        end
        default: begin
          len = $urandom_range(1, 8);
          send(cmd_item(CMD_STOP));
          repeat (len) send(tick_item());
          send(cmd_item(CMD_START));
          sent += len + 2;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(8, 64);
    end else begin
      ready_left <= ready_left - 1;
    end
    ready_count <= ready_count + 8'd1;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (ready_count[1:0] == 2'd0);
      default: out_ready <= (ready_count[2:0] != 3'd0);
    endcase
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_fifo.size() == 0) begin
        $display("%0t: item expected none actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = status_fifo.pop_front();
        check_field("tx_valid", want.tx_valid, out_data.tx_valid);
        check_field("tx_byte", want.tx_byte, out_data.tx_byte);
        check_field("on_led", want.on_led, out_data.on_led);
        check_field("reverse_led", want.reverse_led, out_data.reverse_led);
        check_field("phase_drive", want.phase_drive, out_data.phase_drive);
        check_field("stepped", want.stepped, out_data.stepped);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].status);
    settle();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;
        1: configure(16'd0, 16'd0);
        2: configure(16'($urandom_range(0, 600)), {8'($urandom_range(0, 255)), 8'hFF});
        3: begin
          configure(16'd40, 16'd1);
          repeat (260) send(cmd_item(CMD_FASTER));
          repeat (20) send(tick_item());
          repeat (260) send(cmd_item(CMD_SLOWER));
          send(cmd_item(CMD_START));
          repeat (10) send(tick_item());
          repeat (3) send(cmd_item(CMD_FASTER));
        end
        4: begin
          configure(16'd65100, {8'($urandom_range(0, 255)), 8'hFF});
          repeat (260) send(cmd_item(CMD_FASTER));
          send(cmd_item(CMD_START));
          tick_until_step();
          tick_until_step();
          settle();
          configure(16'd120, 16'h0000);
          pacing = 1'b0;
          tick_until_step();
          send(cmd_item(CMD_STOP));
          while (m_wait != 16'd0) send(tick_item());
          repeat (4) send(tick_item());
          pacing = 1'b1;
          send(cmd_item(CMD_START));
        end
        default: configure(16'($urandom_range(0, 400)),
                           {8'($urandom_range(0, 255)), 8'($urandom_range(0, 40))});
      endcase
      random_traffic(55);
      settle();
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(64'd8_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
